@@ rtl/greedy_line_justifier_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef GREEDY_LINE_JUSTIFIER_CORE_MACROS_SVH
`define GREEDY_LINE_JUSTIFIER_CORE_MACROS_SVH

// Property checked while out of reset.
`define GLJ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("glj assertion failed");

// Property checked at every edge, reset included.
`define GLJ_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("glj assertion failed");

`endif

@@ rtl/glj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glj_pkg
// Shared constants, types and memory interface structs of the line justifier.
// ----------------------------------------------------------------------------
package glj_pkg;

   localparam int LINE_MAX  = 32;
   localparam int WORDS_MAX = (LINE_MAX + 1) / 2;
   localparam int PTR_W     = $clog2(LINE_MAX);
   localparam int CNT_W     = $clog2(LINE_MAX + 2);
   localparam int WIDX_W    = $clog2(WORDS_MAX);
   localparam int WCNT_W    = $clog2(WORDS_MAX + 1);
   localparam int CH_W      = 8;
   localparam int LW_W      = 6;

   localparam logic [CH_W-1:0] CH_HYPHEN = 8'h2D;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CH_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

   localparam logic [LW_W-1:0] LINE_WIDTH_RST = 6'd32;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FINISH,
      ST_ERROR,
      ST_FL_INIT,
      ST_FL_DIV,
      ST_FL_SP,
      ST_FL_LEN,
      ST_FL_LENW,
      ST_FL_RD,
      ST_FL_EMIT,
      ST_FL_PAD,
      ST_CP_RD,
      ST_CP_WR,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic              pw_we;
      logic [PTR_W-1:0]  pw_waddr;
      logic [CH_W-1:0]   pw_wdata;
      logic [PTR_W-1:0]  pw_raddr;
      logic              ls_we;
      logic [PTR_W-1:0]  ls_waddr;
      logic [CH_W-1:0]   ls_wdata;
      logic [PTR_W-1:0]  ls_raddr;
      logic              wl_we;
      logic [WIDX_W-1:0] wl_waddr;
      logic [CNT_W-1:0]  wl_wdata;
      logic [WIDX_W-1:0] wl_raddr;
   } mem_req_type;

   typedef struct packed {
      logic [CH_W-1:0]  pw_rdata;
      logic [CH_W-1:0]  ls_rdata;
      logic [CNT_W-1:0] wl_rdata;
   } mem_rsp_type;

   typedef struct packed {
      logic              done;
      logic [CNT_W-1:0]  quo;
      logic [WCNT_W-1:0] rem;
   } div_res_type;

endpackage

@@ rtl/greedy_line_justifier_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_line_justifier_core
// Greedy full-justification of a byte stream into fixed-width lines.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per transaction, or an end marker that
// closes the pending word and flushes the last line. Output channel rsp_*:
// one character per transaction, line_end on the last of each line, or a
// single error transaction after which all input is dropped until reset.
// A word end copies the word from the pending RAM into the line RAM. A line
// flush emits line_width characters (clamped to the range 1 to LINE_MAX):
// spaces, letters (line RAM read then emit), a gap close and a length RAM
// read per word, a set-up step, and a spacing divide when the line holds
// two or more words.
// req_stall is high whenever an item is in progress.
// A stalled receiver holds the output register and pauses the emitting states.
// Reset clears state, counters, error flag and rsp_valid and sets line_width
// to 32; the RAMs need no clearing as nothing is read before it is written.
// line_width is written through the APB port at byte address 0.
// ----------------------------------------------------------------------------
module greedy_line_justifier_core import glj_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [CH_W-1:0] req_char_in,
   input  logic            req_end_of_text,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [CH_W-1:0] rsp_char_out,
   output logic            rsp_line_end,
   output logic            rsp_error,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready
);

   localparam logic [2:0] ADDR_LINE_WIDTH = 3'd0;

   logic [LW_W-1:0]   line_width_ff, line_width_in;
   mem_req_type       mem_req;
   mem_rsp_type       mem_rsp;
   logic              div_start;
   logic [CNT_W-1:0]  div_dividend;
   logic [WCNT_W-1:0] div_divisor;
   div_res_type       div_res;

   assign pready = 1'b1;

   always_comb begin
      line_width_in = line_width_ff;
      if (psel && penable && pwrite && paddr == ADDR_LINE_WIDTH) begin
         line_width_in = pwdata[LW_W-1:0];
      end
      prdata = (paddr == ADDR_LINE_WIDTH) ? 32'(line_width_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RST;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   glj_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .line_width      (line_width_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_line_end    (rsp_line_end),
      .rsp_error       (rsp_error),
      .mem_req         (mem_req),
      .mem_rsp         (mem_rsp),
      .div_start       (div_start),
      .div_dividend    (div_dividend),
      .div_divisor     (div_divisor),
      .div_res         (div_res)
   );

   glj_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   glj_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_res)
   );

endmodule

@@ rtl/glj_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glj_store
// Pending word, line letters and word lengths: synchronous RAMs, registered read.
// ----------------------------------------------------------------------------
module glj_store import glj_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output mem_rsp_type mem_rsp
);

   logic [CH_W-1:0]  pw_mem [LINE_MAX];
   logic [CH_W-1:0]  ls_mem [LINE_MAX];
   logic [CNT_W-1:0] wl_mem [WORDS_MAX];

   logic [CH_W-1:0]  pw_rdata_ff;
   logic [CH_W-1:0]  ls_rdata_ff;
   logic [CNT_W-1:0] wl_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.pw_we) begin
         pw_mem[mem_req.pw_waddr] <= mem_req.pw_wdata;
      end
      if (mem_req.ls_we) begin
         ls_mem[mem_req.ls_waddr] <= mem_req.ls_wdata;
      end
      if (mem_req.wl_we) begin
         wl_mem[mem_req.wl_waddr] <= mem_req.wl_wdata;
      end
      pw_rdata_ff <= pw_mem[mem_req.pw_raddr];
      ls_rdata_ff <= ls_mem[mem_req.ls_raddr];
      wl_rdata_ff <= wl_mem[mem_req.wl_raddr];
   end

   assign mem_rsp.pw_rdata = pw_rdata_ff;
   assign mem_rsp.ls_rdata = ls_rdata_ff;
   assign mem_rsp.wl_rdata = wl_rdata_ff;

endmodule

@@ rtl/glj_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glj_div
// Restoring divider, one quotient bit per cycle: spare spaces over gap count.
// ----------------------------------------------------------------------------
module glj_div import glj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  dividend,
   input  logic [WCNT_W-1:0] divisor,
   output div_res_type       result
);

   localparam int STEP_W = $clog2(CNT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

   logic              busy_ff,  busy_in;
   logic              done_ff,  done_in;
   logic [STEP_W-1:0] step_ff,  step_in;
   logic [CNT_W-1:0]  dvd_ff,   dvd_in;
   logic [WCNT_W-1:0] dvs_ff,   dvs_in;
   logic [WCNT_W-1:0] rem_ff,   rem_in;
   logic [CNT_W-1:0]  quo_ff,   quo_in;
   logic [CNT_W-1:0]  trial;
   logic [CNT_W-1:0]  diff;
   logic              ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      trial   = {rem_ff, dvd_ff[CNT_W-1]};
      diff    = trial - CNT_W'(dvs_ff);
      ge      = trial >= CNT_W'(dvs_ff);
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[WCNT_W-1:0] : trial[WCNT_W-1:0];
         quo_in  = {quo_ff[CNT_W-2:0], ge};
         dvd_in  = {dvd_ff[CNT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign result.done = done_ff;
   assign result.quo  = quo_ff;
   assign result.rem  = rem_ff;

endmodule

@@ rtl/glj_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glj_seq
// Sequencer: gathers words, packs lines, walks the stores to emit a line.
// ----------------------------------------------------------------------------
module glj_seq import glj_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [LW_W-1:0]   line_width,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CH_W-1:0]   req_char_in,
   input  logic              req_end_of_text,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CH_W-1:0]   rsp_char_out,
   output logic              rsp_line_end,
   output logic              rsp_error,
   output mem_req_type       mem_req,
   input  mem_rsp_type       mem_rsp,
   output logic              div_start,
   output logic [CNT_W-1:0]  div_dividend,
   output logic [WCNT_W-1:0] div_divisor,
   input  div_res_type       div_res
);

   localparam logic [CNT_W-1:0]  LMAX   = CNT_W'(LINE_MAX);
   localparam logic [WCNT_W-1:0] WMAX   = WCNT_W'(WORDS_MAX);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  plen_ff, plen_in;
   logic [CNT_W-1:0]  letters_ff, letters_in;
   logic [WCNT_W-1:0] words_ff, words_in;
   logic              brk_ff, brk_in;
   logic              failed_ff, failed_in;
   logic              hyph_ff, hyph_in;
   logic              eot_ff, eot_in;
   logic              ret_end_ff, ret_end_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  ci_ff, ci_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [WCNT_W-1:0] wi_ff, wi_in;
   logic [WCNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0]  wrem_ff, wrem_in;
   logic [CNT_W-1:0]  src_ff, src_in;
   logic [CNT_W-1:0]  gap_ff, gap_in;
   logic [CNT_W-1:0]  avg_ff, avg_in;
   logic [WCNT_W-1:0] rem_ff, rem_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]   rsp_char_ff, rsp_char_in;
   logic              rsp_end_ff, rsp_end_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [CNT_W-1:0]  w;
   logic [CNT_W-1:0]  spaces;
   logic [CNT_W:0]    fit_sum;
   logic [CNT_W:0]    lsum;
   logic [CNT_W-1:0]  copy_addr;
   logic              can_emit;
   logic              emit;
   logic [CH_W-1:0]   emit_char;
   logic              emit_err;
   logic              line_done;
   logic              is_sep;

   always_comb begin
      if (line_width == '0) begin
         w = CNT_W'(1);
      end else if (CNT_W'(line_width) > LMAX) begin
         w = LMAX;
      end else begin
         w = CNT_W'(line_width);
      end
   end

   assign can_emit  = !rsp_valid_ff || !rsp_stall;
   assign spaces    = (letters_ff < w) ? (w - letters_ff) : '0;
   assign fit_sum   = {1'b0, letters_ff} + {1'b0, len_ff} + (CNT_W + 1)'(words_ff);
   assign lsum      = {1'b0, letters_ff} + {1'b0, len_ff};
   assign copy_addr = letters_ff + ci_ff;
   assign is_sep    = (req_char_in == CH_SPACE) || (req_char_in == CH_LF)
                      || (req_char_in == CH_CR);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      plen_in      = plen_ff;
      letters_in   = letters_ff;
      words_in     = words_ff;
      brk_in       = brk_ff;
      failed_in    = failed_ff;
      hyph_in      = hyph_ff;
      eot_in       = eot_ff;
      ret_end_in   = ret_end_ff;
      len_in       = len_ff;
      ci_in        = ci_ff;
      pos_in       = pos_ff;
      wi_in        = wi_ff;
      n_in         = n_ff;
      wrem_in      = wrem_ff;
      src_in       = src_ff;
      gap_in       = gap_ff;
      avg_in       = avg_ff;
      rem_in       = rem_ff;
      emit         = 1'b0;
      emit_char    = CH_SPACE;
      emit_err     = 1'b0;
      line_done    = 1'b0;
      div_start    = 1'b0;
      div_dividend = spaces;
      div_divisor  = n_ff - 1'b1;

      mem_req          = '0;
      mem_req.pw_waddr = plen_ff[PTR_W-1:0];
      mem_req.pw_wdata = req_char_in;
      mem_req.pw_raddr = ci_ff[PTR_W-1:0];
      mem_req.ls_waddr = copy_addr[PTR_W-1:0];
      mem_req.ls_wdata = mem_rsp.pw_rdata;
      mem_req.ls_raddr = src_ff[PTR_W-1:0];
      mem_req.wl_waddr = words_ff[WIDX_W-1:0];
      mem_req.wl_wdata = len_ff;
      mem_req.wl_raddr = wi_ff[WIDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !failed_ff) begin
               if (req_end_of_text) begin
                  eot_in  = 1'b1;
                  hyph_in = 1'b0;
                  if (plen_ff != '0) begin
                     len_in   = plen_ff;
                     plen_in  = '0;
                     state_in = ST_FINISH;
                  end else if (words_ff != '0) begin
                     ret_end_in = 1'b1;
                     state_in   = ST_FL_INIT;
                  end else begin
                     letters_in = '0;
                     brk_in     = 1'b0;
                  end
               end else if (req_char_in == CH_HYPHEN) begin
                  mem_req.pw_we = (plen_ff < LMAX);
                  len_in   = (plen_ff <= LMAX) ? plen_ff + 1'b1 : plen_ff;
                  plen_in  = '0;
                  hyph_in  = 1'b1;
                  eot_in   = 1'b0;
                  state_in = ST_FINISH;
               end else if (is_sep) begin
                  len_in   = plen_ff;
                  plen_in  = '0;
                  hyph_in  = 1'b0;
                  eot_in   = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  mem_req.pw_we = (plen_ff < LMAX);
                  if (plen_ff <= LMAX) begin
                     plen_in = plen_ff + 1'b1;
                  end
               end
            end
         end

         ST_FINISH: begin
            ci_in = '0;
            if (len_ff == '0 || len_ff > w) begin
               state_in = ST_ERROR;
            end else if (words_ff != '0
                         && (brk_ff || fit_sum > {1'b0, w})) begin
               ret_end_in = 1'b0;
               state_in   = ST_FL_INIT;
            end else begin
               state_in = ST_CP_RD;
            end
         end

         ST_ERROR: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_err  = 1'b1;
               emit_char = '0;
               failed_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end

         ST_FL_INIT: begin
            pos_in = '0;
            wi_in  = '0;
            src_in = '0;
            n_in   = (words_ff > WMAX) ? WMAX : words_ff;
            if (words_ff == WCNT_W'(1)) begin
               gap_in   = (spaces + 1'b1) >> 1;
               state_in = ST_FL_SP;
            end else if (words_ff == '0) begin
               state_in = ST_FL_PAD;
            end else begin
               div_start   = 1'b1;
               div_divisor = ((words_ff > WMAX) ? WMAX : words_ff) - 1'b1;
               state_in    = ST_FL_DIV;
            end
         end

         ST_FL_DIV: begin
            if (div_res.done) begin
               // fewer spaces than gaps: one space per gap, line gets cut
               if (div_res.quo == '0) begin
                  avg_in = CNT_W'(1);
                  rem_in = '0;
               end else begin
                  avg_in = div_res.quo;
                  rem_in = div_res.rem;
               end
               gap_in   = '0;
               state_in = ST_FL_SP;
            end
         end

         ST_FL_SP: begin
            if (gap_ff != '0) begin
               if (can_emit) begin
                  emit   = 1'b1;
                  gap_in = gap_ff - 1'b1;
               end
            end else begin
               state_in = ST_FL_LEN;
            end
         end

         ST_FL_LEN: begin
            state_in = ST_FL_LENW;
         end

         ST_FL_LENW: begin
            wrem_in  = mem_rsp.wl_rdata;
            state_in = ST_FL_RD;
         end

         ST_FL_RD: begin
            if (wrem_ff == '0 || src_ff == LMAX) begin
               wi_in = wi_ff + 1'b1;
               if (wi_ff + 1'b1 == n_ff) begin
                  state_in = ST_FL_PAD;
               end else begin
                  gap_in   = avg_ff + CNT_W'(rem_ff != '0);
                  rem_in   = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;
                  state_in = ST_FL_SP;
               end
            end else begin
               state_in = ST_FL_EMIT;
            end
         end

         ST_FL_EMIT: begin
            if (can_emit) begin
               emit      = 1'b1;
               emit_char = mem_rsp.ls_rdata;
               src_in    = src_ff + 1'b1;
               wrem_in   = wrem_ff - 1'b1;
               state_in  = ST_FL_RD;
            end
         end

         ST_FL_PAD: begin
            if (can_emit) begin
               emit = 1'b1;
            end
         end

         ST_CP_RD: begin
            if (ci_ff < len_ff && copy_addr < LMAX && words_ff < WMAX) begin
               state_in = ST_CP_WR;
            end else begin
               state_in = ST_COMMIT;
            end
         end

         ST_CP_WR: begin
            mem_req.ls_we = 1'b1;
            ci_in         = ci_ff + 1'b1;
            state_in      = ST_CP_RD;
         end

         ST_COMMIT: begin
            if (words_ff < WMAX) begin
               mem_req.wl_we = 1'b1;
               words_in      = words_ff + 1'b1;
               letters_in    = (lsum > (CNT_W + 1)'(LINE_MAX)) ? LMAX
                                                               : lsum[CNT_W-1:0];
            end
            brk_in = hyph_ff;
            if (eot_ff) begin
               ret_end_in = 1'b1;
               state_in   = ST_FL_INIT;
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // every line character advances pos; the line closes at width
      if (emit && !emit_err) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff + 1'b1 == w) begin
            line_done  = 1'b1;
            letters_in = '0;
            words_in   = '0;
            brk_in     = 1'b0;
            ci_in      = '0;
            state_in   = ret_end_ff ? ST_IDLE : ST_CP_RD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_err_in   = rsp_err_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_end_in   = line_done;
         rsp_err_in   = emit_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plen_ff      <= '0;
         letters_ff   <= '0;
         words_ff     <= '0;
         brk_ff       <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plen_ff      <= plen_in;
         letters_ff   <= letters_in;
         words_ff     <= words_in;
         brk_ff       <= brk_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hyph_ff     <= hyph_in;
      eot_ff      <= eot_in;
      ret_end_ff  <= ret_end_in;
      len_ff      <= len_in;
      ci_ff       <= ci_in;
      pos_ff      <= pos_in;
      wi_ff       <= wi_in;
      n_ff        <= n_in;
      wrem_ff     <= wrem_in;
      src_ff      <= src_in;
      gap_ff      <= gap_in;
      avg_ff      <= avg_in;
      rem_ff      <= rem_in;
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_line_end = rsp_end_ff;
   assign rsp_error    = rsp_err_ff;

endmodule

@@ rtl/glj_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glj_checker
// Port-level checks of the line justifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "greedy_line_justifier_core_macros.svh"

module glj_checker import glj_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input logic [CH_W-1:0] rsp_char_out,
   input logic            rsp_line_end,
   input logic            rsp_error
);

   `GLJ_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `GLJ_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)
   `GLJ_ASSERT(a_err_shape, clock, reset,
      rsp_valid && rsp_error |-> rsp_char_out == '0 && !rsp_line_end)
   `GLJ_ASSERT(a_err_last, clock, reset,
      rsp_valid && !rsp_stall && rsp_error |=> !rsp_valid)

endmodule

bind greedy_line_justifier_core glj_checker u_glj_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_char_out (rsp_char_out),
   .rsp_line_end (rsp_line_end),
   .rsp_error    (rsp_error)
);
